// ===== rtl/mcw_pkg.sv =====
package mcw_pkg;

  localparam int SLOTS      = 32;
  localparam int TIME_W     = 32;
  localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int MODE_W     = 3;
  localparam int CH_W       = 5;
  localparam int GRANT_W    = 5;
  localparam int COUNT_W    = 6;
  localparam int TIMEOUT_W  = 31;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(1000);
  localparam logic [COUNT_W-1:0]   COUNT_MAX     = '1;

  localparam logic [MODE_W-1:0] MODE_TICK     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_REGISTER = 3'd1;
  localparam logic [MODE_W-1:0] MODE_KICK     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RELEASE  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CHECK    = 3'd4;

  typedef enum logic {
    OP_REGISTER,
    OP_CHECK
  } sweep_op_t;

  // record that walks the cell row, one cell per cycle
  typedef struct packed {
    logic               valid;
    sweep_op_t          op;
    logic               found;
    logic [IDX_W-1:0]   slot;
    logic [COUNT_W-1:0] count;
  } carry_t;

  // single-cycle operations broadcast to every cell
  typedef struct packed {
    logic            kick_en;
    logic            rel_en;
    logic [CH_W-1:0] channel;
  } ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/mcw_cell.sv =====
module mcw_cell import mcw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [IDX_W-1:0]     cell_index,
  input  carry_t               carry_in,
  output carry_t               carry_out,
  input  ctrl_t                ctrl,
  input  logic [TIME_W-1:0]    now_ticks,
  input  logic [TIMEOUT_W-1:0] timeout_ticks,
  output logic                 active
);

  logic [TIME_W-1:0] stamp;
  logic [TIME_W-1:0] elapsed;
  logic              hit;
  logic              claim;
  logic              expired;
  carry_t            carry_next;

  assign hit     = (32'(ctrl.channel) == 32'(cell_index));
  assign claim   = carry_in.valid && (carry_in.op == OP_REGISTER) && !carry_in.found && !active;
  assign elapsed = now_ticks - stamp;
  assign expired = (64'(elapsed) > 64'(timeout_ticks));

  always_comb begin
    carry_next = carry_in;
    if (claim) begin
      carry_next.found = 1'b1;
      carry_next.slot  = cell_index;
    end
    if (carry_in.valid && (carry_in.op == OP_CHECK) && active && expired &&
        (carry_in.count != COUNT_MAX)) begin
      carry_next.count = carry_in.count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carry_out.valid <= 1'b0;
    end else begin
      carry_out <= carry_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (claim) begin
      active <= 1'b1;
    end else if (ctrl.rel_en && hit) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (claim || (ctrl.kick_en && hit && active)) begin
      stamp <= now_ticks;
    end
  end

endmodule

// ===== rtl/multi_channel_watchdog.sv =====
// Deadlock watchdog over SLOTS channel slots held in a row of cells, one slot
// per cell, plus a global tick counter. Input word on s_tdata: mode (tick,
// register, kick, release, check) and channel; one result word per input on
// m_tdata. Tick, kick, release and unused modes load the result register at
// once; such words can be accepted every cycle while the result side keeps
// up. Register and check send a record down the cell row one cell per cycle,
// then into a hold register; no new word is accepted during that walk.
// timeout_ticks resets to 1000 and is written through cfg_we and cfg_wdata;
// the user must do so only while the block is idle, which is not enforced.
module multi_channel_watchdog import mcw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [TIMEOUT_W-1:0]  cfg_wdata,     // timeout_ticks
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,       // mode[2:0], channel[7:3]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata        // granted_slot[4:0], table_full[5],
                                               // alarm[6], expired_count[12:7],
                                               // none_active[13], zero[15:14]
);

  state_t               state;
  state_t               state_next;
  logic [TIMEOUT_W-1:0] timeout_ticks;
  logic [TIME_W-1:0]    now_ticks;
  logic [MODE_W-1:0]    mode;
  logic [CH_W-1:0]      channel;
  logic                 accept;
  logic                 is_sweep;
  logic                 out_free;
  logic                 load_now;
  logic                 load_done;
  carry_t               chain [SLOTS+1];
  ctrl_t                ctrl;
  logic [SLOTS-1:0]     active;
  logic [SLOTS-1:0]     active_after;
  carry_t               held;

  assign mode     = s_tdata[MODE_W-1:0];
  assign channel  = s_tdata[MODE_W +: CH_W];
  assign out_free = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign is_sweep = (mode == MODE_REGISTER) || (mode == MODE_CHECK);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && is_sweep) begin
          state_next = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (chain[SLOTS].valid) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    load_done = 1'b0;
    case (state)
      ST_IDLE:  s_tready = out_free;
      ST_SWEEP: s_tready = 1'b0;
      ST_DONE:  load_done = out_free;
      default: begin
        s_tready  = 1'b0;
        load_done = 1'b0;
      end
    endcase
  end

  assign load_now = accept && !is_sweep;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_ticks <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now_ticks <= '0;
    end else if (accept && (mode == MODE_TICK)) begin
      now_ticks <= now_ticks + 1'b1;
    end
  end

  always_comb begin
    chain[0].valid = accept && is_sweep;
    chain[0].op    = (mode == MODE_CHECK) ? OP_CHECK : OP_REGISTER;
    chain[0].found = 1'b0;
    chain[0].slot  = '0;
    chain[0].count = '0;
  end

  assign ctrl.kick_en = accept && (mode == MODE_KICK);
  assign ctrl.rel_en  = accept && (mode == MODE_RELEASE);
  assign ctrl.channel = channel;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    mcw_cell u_cell (
      .clk           (clk),
      .rst           (rst),
      .cell_index    (IDX_W'(i)),
      .carry_in      (chain[i]),
      .carry_out     (chain[i+1]),
      .ctrl          (ctrl),
      .now_ticks     (now_ticks),
      .timeout_ticks (timeout_ticks),
      .active        (active[i])
    );
  end

  // active bits as they will stand once a release in this cycle lands
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      active_after[i] = active[i] && !(ctrl.rel_en && (32'(channel) == i));
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_SWEEP) && chain[SLOTS].valid) begin
      held <= chain[SLOTS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_now || load_done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_now) begin
      m_tdata <= {2'b00, !(|active_after), {COUNT_W{1'b0}}, 1'b0, 1'b0, {GRANT_W{1'b0}}};
    end else if (load_done) begin
      if (held.op == OP_REGISTER) begin
        m_tdata <= {2'b00, !(|active), {COUNT_W{1'b0}}, 1'b0, !held.found,
                    held.found ? GRANT_W'(held.slot) : {GRANT_W{1'b0}}};
      end else begin
        m_tdata <= {2'b00, !(|active), held.count, (held.count != '0), 1'b0,
                    {GRANT_W{1'b0}}};
      end
    end
  end

endmodule

// ===== bench/multi_channel_watchdog_tb.sv =====
module multi_channel_watchdog_tb;
  import mcw_pkg::*;

  // modes the block leaves alone
  localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_C = 3'd7;

  localparam int STUCK_LIMIT  = 2000;
  localparam int PHASE_WORDS  = 240;
  localparam int DRAIN_CYCLES = 40;

  // msb to lsb, so the struct lines up with m_tdata[13:0]
  typedef struct packed {
    logic               none_active;
    logic [COUNT_W-1:0] expired_count;
    logic               alarm;
    logic               table_full;
    logic [GRANT_W-1:0] granted_slot;
  } wd_result_t;

  typedef struct packed {
    logic       fixed;
    wd_result_t r;
  } typed_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CH_W-1:0]   ch;
    logic              fixed;
    wd_result_t        want;  // {none_active, expired_count, alarm, table_full, granted_slot}
  } dir_row_t;

  localparam wd_result_t IDLE_RES = '{1'b1, 6'd0, 1'b0, 1'b0, 5'd0};
  localparam wd_result_t BUSY_RES = '{1'b0, 6'd0, 1'b0, 1'b0, 5'd0};
  localparam int DIR_ROWS = 22;

  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{MODE_CHECK,    5'd0,  1'b1, IDLE_RES},
    '{MODE_TICK,     5'd0,  1'b1, IDLE_RES},
    '{MODE_KICK,     5'd31, 1'b1, IDLE_RES},   // kick on a free slot
    '{MODE_RELEASE,  5'd0,  1'b1, IDLE_RES},   // release on a free slot
    '{MODE_SPARE_A,  5'd31, 1'b1, IDLE_RES},
    '{MODE_SPARE_B,  5'd21, 1'b1, IDLE_RES},
    '{MODE_SPARE_C,  5'd10, 1'b1, IDLE_RES},
    '{MODE_REGISTER, 5'd31, 1'b1, BUSY_RES},   // channel is ignored on register
    '{MODE_REGISTER, 5'd0,  1'b1, '{1'b0, 6'd0, 1'b0, 1'b0, 5'd1}},
    '{MODE_REGISTER, 5'd0,  1'b1, '{1'b0, 6'd0, 1'b0, 1'b0, 5'd2}},
    '{MODE_RELEASE,  5'd1,  1'b1, BUSY_RES},
    '{MODE_REGISTER, 5'd0,  1'b1, '{1'b0, 6'd0, 1'b0, 1'b0, 5'd1}},  // lowest free
    '{MODE_KICK,     5'd2,  1'b0, '0},
    '{MODE_TICK,     5'd7,  1'b0, '0},
    '{MODE_TICK,     5'd24, 1'b0, '0},
    '{MODE_CHECK,    5'd31, 1'b0, '0},
    '{MODE_SPARE_C,  5'd31, 1'b0, '0},
    '{MODE_RELEASE,  5'd0,  1'b0, '0},
    '{MODE_RELEASE,  5'd1,  1'b0, '0},
    '{MODE_RELEASE,  5'd2,  1'b1, IDLE_RES},
    '{MODE_RELEASE,  5'd2,  1'b1, IDLE_RES},
    '{MODE_CHECK,    5'd0,  1'b1, IDLE_RES}
  };

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [TIMEOUT_W-1:0]  cfg_wdata = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;      // mode[2:0], channel[7:3]
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;             // granted_slot[4:0], table_full[5],
                                              // alarm[6], expired_count[12:7],
                                              // none_active[13], zero[15:14]

  // watchdog shadow state
  logic [TIME_W-1:0]    now_q;
  logic [TIME_W-1:0]    stamp_q [SLOTS];
  logic [SLOTS-1:0]     active_q;
  logic [TIMEOUT_W-1:0] timeout_q;

  wd_result_t expected_results [$];
  typed_t     typed_results [$];

  int  words_sent   = 0;
  int  results_seen = 0;
  int  errors       = 0;
  int  full_seen    = 0;
  int  alarm_seen   = 0;
  int  stuck_cycles = 0;
  int  stall_left   = 0;
  bit  quiet        = 1'b0;

  multi_channel_watchdog i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic wd_result_t watchdog_predict(logic [MODE_W-1:0] mode,
                                                  logic [CH_W-1:0] ch);
    wd_result_t r;
    int         n;
    r = '0;
    n = 0;
    case (mode)
      MODE_TICK: begin
        now_q = now_q + 1'b1;
      end
      MODE_REGISTER: begin
        r.table_full = 1'b1;
        for (int i = 0; i < SLOTS; i++) begin
          if (!active_q[i] && r.table_full) begin
            active_q[i]    = 1'b1;
            stamp_q[i]     = now_q;
            r.granted_slot = GRANT_W'(i);
            r.table_full   = 1'b0;
          end
        end
      end
      MODE_KICK: begin
        if (active_q[ch]) stamp_q[ch] = now_q;
      end
      MODE_RELEASE: begin
        active_q[ch] = 1'b0;
      end
      MODE_CHECK: begin
        for (int i = 0; i < SLOTS; i++) begin
          // elapsed time is modulo 2^TIME_W, unsigned compare
          if (active_q[i] && (now_q - stamp_q[i]) > TIME_W'(timeout_q) && n < 63) n++;
        end
        r.expired_count = COUNT_W'(n);
        r.alarm         = (n != 0);
      end
      default: begin
      end
    endcase
    r.none_active = (active_q == '0);
    return r;
  endfunction

  // shadow model update at acceptance, result checking
  always @(posedge clk) begin : monitor
    wd_result_t got;
    wd_result_t want;
    wd_result_t pred;
    typed_t     t;
    if (rst) begin
      now_q     = '0;
      active_q  = '0;
      timeout_q = TIMEOUT_RESET;
    end else begin
      if (cfg_we) timeout_q = cfg_wdata;
      if (s_tvalid && s_tready) begin
        t = '0;
        if (typed_results.size() > 0) t = typed_results.pop_front();
        pred = watchdog_predict(s_tdata[2:0], s_tdata[7:3]);
        expected_results.push_back(t.fixed ? t.r : pred);
      end
      if (m_tvalid && m_tready) begin
        results_seen++;
        got = wd_result_t'(m_tdata[13:0]);
        if (got.table_full) full_seen++;
        if (got.alarm) alarm_seen++;
        if (m_tdata[15:14] != 2'b00) begin
          $error("pad bits: expected 0, got %0d", m_tdata[15:14]);
          errors++;
        end
        if (expected_results.size() == 0) begin
          $error("result word %h with nothing expected", m_tdata);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got.granted_slot != want.granted_slot) begin
            $error("granted_slot: expected %0d, got %0d", want.granted_slot, got.granted_slot);
            errors++;
          end
          if (got.table_full != want.table_full) begin
            $error("table_full: expected %0d, got %0d", want.table_full, got.table_full);
            errors++;
          end
          if (got.alarm != want.alarm) begin
            $error("alarm: expected %0d, got %0d", want.alarm, got.alarm);
            errors++;
          end
          if (got.expired_count != want.expired_count) begin
            $error("expired_count: expected %0d, got %0d", want.expired_count,
                   got.expired_count);
            errors++;
          end
          if (got.none_active != want.none_active) begin
            $error("none_active: expected %0d, got %0d", want.none_active, got.none_active);
            errors++;
          end
        end
      end
    end
  end

  // result side backpressure
  always @(posedge clk) begin
    if (rst || quiet) begin
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 8);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles == STUCK_LIMIT) begin
      $display("multi_channel_watchdog_tb: done, errors");
      $finish;
    end
  end

  task automatic send_word(input logic [MODE_W-1:0] mode, input logic [CH_W-1:0] ch,
                           input logic fixed, input wd_result_t want);
    typed_results.push_back('{fixed, want});
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {ch, mode};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_sent++;
  endtask

  // hold the sender until every word sent has come back
  task automatic wait_results_done();
    s_tvalid <= 1'b0;
    while (results_seen < words_sent) @(posedge clk);
  endtask

  initial begin
    logic [TIMEOUT_W-1:0] timeouts [6];
    int                   reg_w;
    int                   pick;
    int                   counted;
    logic [CH_W-1:0]      ch;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int k = 0; k < DIR_ROWS; k++)
      send_word(DIRECTED[k].mode, DIRECTED[k].ch, DIRECTED[k].fixed, DIRECTED[k].want);

    timeouts[0] = '0;
    timeouts[1] = TIMEOUT_W'(1);
    timeouts[2] = '1;
    timeouts[3] = TIMEOUT_W'($urandom_range(2, 40));
    timeouts[4] = TIMEOUT_W'($urandom());
    timeouts[5] = TIMEOUT_W'(3);

    for (int p = 0; p < 6; p++) begin
      wait_results_done();
      repeat (3) @(posedge clk);
      cfg_wdata <= timeouts[p];
      cfg_we    <= 1'b1;
      @(posedge clk);
      cfg_we    <= 1'b0;
      if (p == 5) quiet = 1'b1;

      if (p == 0) begin
        // fill every slot, overflow once, age all by one tick, then empty out
        for (int i = 0; i < SLOTS; i++) send_word(MODE_REGISTER, CH_W'($urandom()), 1'b0, '0);
        send_word(MODE_REGISTER, 5'd0, 1'b1, '{1'b0, 6'd0, 1'b0, 1'b1, 5'd0});
        send_word(MODE_TICK, 5'd0, 1'b0, '0);
        send_word(MODE_CHECK, 5'd0, 1'b1, '{1'b0, 6'd32, 1'b1, 1'b0, 5'd0});
        for (int i = 0; i < SLOTS; i++) send_word(MODE_RELEASE, CH_W'(i), 1'b0, '0);
        send_word(MODE_CHECK, 5'd0, 1'b1, IDLE_RES);
      end

      // weights: tick 35, register reg_w, kick 18, release 35-reg_w, check 8, spare 4
      reg_w   = $urandom_range(10, 25);
      counted = 0;
      while (counted < PHASE_WORDS) begin
        pick = $urandom_range(0, 99);
        ch   = CH_W'($urandom());
        counted++;
        if (pick < 35)
          send_word(MODE_TICK, ch, 1'b0, '0);
        else if (pick < 35 + reg_w)
          send_word(MODE_REGISTER, ch, 1'b0, '0);
        else if (pick < 53 + reg_w)
          send_word(MODE_KICK, ch, 1'b0, '0);
        else if (pick < 88)
          send_word(MODE_RELEASE, ch, 1'b0, '0);
        else if (pick < 96)
          send_word(MODE_CHECK, ch, 1'b0, '0);
        else begin
          counted--;
          send_word(MODE_W'($urandom_range(MODE_SPARE_A, MODE_SPARE_C)), ch, 1'b0, '0);
        end
      end
    end

    wait_results_done();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d results still outstanding", expected_results.size());
      errors++;
    end
    $display("covered %0d words: directed rows, full-table fill, 6 timeout settings",
             words_sent);
    $display("saw %0d table-full grants and %0d alarming checks", full_seen, alarm_seen);
    if (errors == 0)
      $display("multi_channel_watchdog_tb: done, clean");
    else
      $display("multi_channel_watchdog_tb: done, errors");
    $finish;
  end

endmodule
